// File: hw/rtl/bctf_pkg.sv
// Shared types, constants and the control store of the time-code frame builder.
`default_nettype none
package bctf_pkg;

  typedef logic [11:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minute_t;
  typedef logic signed [3:0] ut1_t;
  typedef logic [60:0] frame_t;
  typedef logic [3:0]  pc_t;
  typedef logic [5:0]  bitpos_t;

  // Frame bit positions.
  localparam bitpos_t POS_DST_NOW  = 6'd2;
  localparam bitpos_t POS_LEAP     = 6'd3;
  localparam bitpos_t POS_YEAR_U   = 6'd4;
  localparam bitpos_t POS_MIN_U    = 6'd10;
  localparam bitpos_t POS_MIN_T    = 6'd15;
  localparam bitpos_t POS_HOUR_U   = 6'd20;
  localparam bitpos_t POS_HOUR_T   = 6'd25;
  localparam bitpos_t POS_DOY_U    = 6'd30;
  localparam bitpos_t POS_DOY_T    = 6'd35;
  localparam bitpos_t POS_DOY_H    = 6'd40;
  localparam bitpos_t POS_UT1_SIGN = 6'd50;
  localparam bitpos_t POS_YEAR_T   = 6'd51;
  localparam bitpos_t POS_DST_END  = 6'd55;
  localparam bitpos_t POS_UT1_MAG  = 6'd56;

  // Daylight-saving constants.
  localparam year_t       DST_FIRST_YEAR = 12'd2007;
  localparam year_t       DST_BASE_YEAR  = 12'd2005;
  localparam logic [6:0]  DST_BASE_DAY   = 7'd72;
  localparam logic [6:0]  DST_MIN_DAY    = 7'd67;
  localparam logic [8:0]  DST_SPAN       = 9'd238;

  // Micro-operations of the sequencer.
  typedef enum logic [2:0] {
    OP_WAIT  = 3'd0,
    OP_INIT  = 3'd1,
    OP_LEAP  = 3'd2,
    OP_MONTH = 3'd3,
    OP_DST   = 3'd4,
    OP_FIX   = 3'd5,
    OP_DIG   = 3'd6,
    OP_EMIT  = 3'd7
  } op_t;

  // Operand select of the divide-by-ten unit.
  typedef enum logic [2:0] {
    SRC_YEAR = 3'd0,
    SRC_TMP  = 3'd1,
    SRC_MIN  = 3'd2,
    SRC_HOUR = 3'd3,
    SRC_DOY  = 3'd4
  } src_t;

  typedef struct packed {
    op_t     op;
    src_t    src;
    bitpos_t rpos;   // where the remainder digit lands
    bitpos_t qpos;   // where the quotient digit lands when qput is set
    logic    qput;
    logic    qkeep;  // keep the quotient for the next digit step
    pc_t     nxt;
  } cword_t;

  localparam pc_t PC_WAIT = 4'd0;
  localparam pc_t PC_FIX  = 4'd5;
  localparam pc_t PC_INIT = 4'd1;

  function automatic cword_t mk(op_t op, src_t src, bitpos_t rpos, bitpos_t qpos,
                                logic qput, logic qkeep, pc_t nxt);
    cword_t w;
    w.op = op; w.src = src; w.rpos = rpos; w.qpos = qpos;
    w.qput = qput; w.qkeep = qkeep; w.nxt = nxt;
    return w;
  endfunction

  // Control store: one word per step.
  function automatic cword_t ucode(pc_t pc);
    cword_t w;
    case (pc)
      4'd0:    w = mk(OP_WAIT,  SRC_YEAR, 6'd0, 6'd0, 1'b0, 1'b0, 4'd1);
      4'd1:    w = mk(OP_INIT,  SRC_YEAR, 6'd0, 6'd0, 1'b0, 1'b0, 4'd2);
      4'd2:    w = mk(OP_LEAP,  SRC_YEAR, 6'd0, 6'd0, 1'b0, 1'b0, 4'd3);
      4'd3:    w = mk(OP_MONTH, SRC_YEAR, 6'd0, 6'd0, 1'b0, 1'b0, 4'd4);
      4'd4:    w = mk(OP_DST,   SRC_YEAR, 6'd0, 6'd0, 1'b0, 1'b0, 4'd5);
      4'd5:    w = mk(OP_FIX,   SRC_YEAR, 6'd0, 6'd0, 1'b0, 1'b0, 4'd6);
      4'd6:    w = mk(OP_DIG, SRC_YEAR, POS_YEAR_U, 6'd0, 1'b0, 1'b1, 4'd7);
      4'd7:    w = mk(OP_DIG, SRC_TMP,  POS_YEAR_T, 6'd0, 1'b0, 1'b0, 4'd8);
      4'd8:    w = mk(OP_DIG, SRC_MIN,  POS_MIN_U,  POS_MIN_T, 1'b1, 1'b0, 4'd9);
      4'd9:    w = mk(OP_DIG, SRC_HOUR, POS_HOUR_U, POS_HOUR_T, 1'b1, 1'b0, 4'd10);
      4'd10:   w = mk(OP_DIG, SRC_DOY,  POS_DOY_U,  6'd0, 1'b0, 1'b1, 4'd11);
      4'd11:   w = mk(OP_DIG, SRC_TMP,  POS_DOY_T,  POS_DOY_H, 1'b1, 1'b0, 4'd12);
      4'd12:   w = mk(OP_EMIT,  SRC_YEAR, 6'd0, 6'd0, 1'b0, 1'b0, PC_WAIT);
      default: w = mk(OP_EMIT,  SRC_YEAR, 6'd0, 6'd0, 1'b0, 1'b0, PC_WAIT);
    endcase
    return w;
  endfunction

  // Days in a month; month zero and months past December add nothing.
  function automatic logic [4:0] month_len(month_t m, logic leap);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bctf_if.sv
// Valid/ready channel interfaces for the date input and the frame output.
`default_nettype none
interface bctf_in_if;
  logic               valid;
  logic               ready;
  bctf_pkg::year_t    utc_year;
  bctf_pkg::month_t   utc_month;
  bctf_pkg::day_t     utc_day;
  bctf_pkg::hour_t    utc_hour;
  bctf_pkg::minute_t  utc_minute;
  bctf_pkg::ut1_t     ut1_offset;
  logic               leap_flag;

  modport source (output valid, utc_year, utc_month, utc_day, utc_hour, utc_minute,
                  ut1_offset, leap_flag, input ready);
  modport sink   (input valid, utc_year, utc_month, utc_day, utc_hour, utc_minute,
                  ut1_offset, leap_flag, output ready);
endinterface

interface bctf_out_if;
  logic              valid;
  logic              ready;
  bctf_pkg::frame_t  frame_bits;

  modport source (output valid, frame_bits, input ready);
  modport sink   (input valid, frame_bits, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bcd_time_code_frame_builder.sv
// Microcoded builder of one minute's BCD time-code frame from a UTC date and time.
// Steps: take the input word, initialise, apply the leap rule, walk the months before the
//   given one, walk the years from 2005 up to the input year, fix the start day, place the digits, emit.
// Input is taken only in the wait step, so a new word waits until the last one is emitted
//   or held; a stalled output word holds the next one in its emit step.
// Reset: rst (synchronous) clears the step counter and the output valid flag only.
`default_nettype none
module bcd_time_code_frame_builder (
  input  logic        clk,
  input  logic        rst,
  bctf_in_if.sink     tc_in,
  bctf_out_if.source  tc_out
);
  import bctf_pkg::*;

  // Sequencer: a step counter addresses the control store. Loop steps hold the
  // counter while their condition stays true; the wait and emit steps hold
  // while their handshake cannot proceed.
  pc_t    pc;
  pc_t    pc_next;
  cword_t cw;

  // Operand registers captured from the input word.
  year_t   year;
  month_t  month;
  hour_t   hour;
  minute_t minute;
  ut1_t    ut1;
  logic    leap;

  // Working registers.
  logic [8:0]  doy;      // day of year, at most 31 + 366
  month_t      mi;       // month loop index
  year_t       t;        // year walked by the daylight-saving loop
  logic [6:0]  tmod100;  // t modulo 100
  logic [1:0]  tcent;    // t divided by 100, modulo 4
  logic [6:0]  r;        // daylight-saving start day candidate
  logic [5:0]  q100;     // year divided by 100
  logic        leapy;    // the input year is a leap year
  logic        dsvalid;  // a start day exists for this year
  logic [8:0]  tmp;      // quotient carried between digit steps
  frame_t      frame;
  logic        out_valid;
  frame_t      out_frame;

  logic accept;
  logic emit_fire;
  logic month_go;
  logic dst_go;

  assign cw       = ucode(pc);
  assign accept   = tc_in.valid && tc_in.ready;
  assign month_go = (mi < month) && (mi <= 4'd12);
  assign dst_go   = (t < year);
  assign emit_fire = (cw.op == OP_EMIT) && (!out_valid || tc_out.ready);

  assign tc_in.ready       = (cw.op == OP_WAIT);
  assign tc_out.valid      = out_valid;
  assign tc_out.frame_bits = out_frame;

  always_comb begin
    pc_next = cw.nxt;
    case (cw.op)
      OP_WAIT:  if (!accept) pc_next = pc;
      OP_MONTH: if (month_go) pc_next = pc;
      OP_DST:   if (dst_go) pc_next = pc;
      OP_EMIT:  if (!emit_fire) pc_next = pc;
      default:  pc_next = cw.nxt;
    endcase
  end

  // Year divided by 100 by a reciprocal multiply; exact for every 12-bit year.
  logic [24:0] prod100;
  assign prod100 = {13'd0, year} * 25'd5243;

  // Remainder of the year by 100, used for the Gregorian century rule.
  logic [12:0] rem100;
  assign rem100 = {1'b0, year} - ({7'd0, q100} * 13'd100);

  // Leap rule of the walked year, from its running residues.
  logic leapt;
  assign leapt = (t[1:0] == 2'b00) && ((tmod100 != 7'd0) || (tcent == 2'b00));

  // One step of the start-day walk: back one weekday, or two after a leap
  // year, wrapping within the week that starts at day 67.
  logic [6:0] r_step;
  logic [6:0] r_dec;
  assign r_dec  = r - 7'd1 - {6'd0, leapt};
  assign r_step = (r_dec < DST_MIN_DAY) ? r_dec + 7'd7 : r_dec;

  // Shared divide-by-ten unit. The reciprocal 6554 / 2^16 gives exact
  // quotients for all operands below 4096.
  logic [11:0] dsrc;
  logic [24:0] dprod;
  logic [8:0]  dq;
  logic [12:0] dq10;
  logic [12:0] ddiff;
  logic [3:0]  dr;

  always_comb begin
    case (cw.src)
      SRC_YEAR: dsrc = year;
      SRC_TMP:  dsrc = {3'd0, tmp};
      SRC_MIN:  dsrc = {6'd0, minute};
      SRC_HOUR: dsrc = {7'd0, hour};
      SRC_DOY:  dsrc = {3'd0, doy};
      default:  dsrc = year;
    endcase
  end

  assign dprod = {13'd0, dsrc} * 25'd6554;
  assign dq    = dprod[24:16];
  assign dq10  = {1'b0, dq, 3'b000} + {3'b000, dq, 1'b0};
  assign ddiff = {1'b0, dsrc} - dq10;
  assign dr    = ddiff[3:0];

  // Final frame: the digits already placed plus the flag bits and the UT1 magnitude.
  logic [3:0]  ut1mag;
  logic [8:0]  ds;
  logic [8:0]  ds_end;
  frame_t      fin;

  assign ut1mag = ut1[3] ? (4'd0 - ut1) : ut1;
  assign ds     = {2'd0, r};
  assign ds_end = ds + DST_SPAN;

  always_comb begin
    fin = frame;
    fin[POS_LEAP] = leap;
    fin[POS_UT1_SIGN] = !ut1[3];
    fin = fin | ({57'd0, ut1mag} << POS_UT1_MAG);
    if (dsvalid) begin
      fin[POS_DST_NOW] = (doy > ds) && (doy <= ds_end);
      fin[POS_DST_END] = (doy >= ds) && (doy < ds_end);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= PC_WAIT;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (tc_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_WAIT: begin
        if (accept) begin
          year   <= tc_in.utc_year;
          month  <= tc_in.utc_month;
          hour   <= tc_in.utc_hour;
          minute <= tc_in.utc_minute;
          ut1    <= tc_in.ut1_offset;
          leap   <= tc_in.leap_flag;
          doy    <= {4'd0, tc_in.utc_day};
        end
      end
      OP_INIT: begin
        q100    <= prod100[24:19];
        mi      <= 4'd1;
        t       <= DST_BASE_YEAR;
        tmod100 <= 7'd5;
        tcent   <= 2'd0;
        r       <= DST_BASE_DAY;
        frame   <= '0;
      end
      OP_LEAP: begin
        leapy <= (year[1:0] == 2'b00) && ((rem100 != 13'd0) || (q100[1:0] == 2'b00));
      end
      OP_MONTH: begin
        if (month_go) begin
          doy <= doy + {4'd0, month_len(mi, leapy)};
          mi  <= mi + 4'd1;
        end
      end
      OP_DST: begin
        if (dst_go) begin
          r <= r_step;
          t <= t + 12'd1;
          if (tmod100 == 7'd99) begin
            tmod100 <= 7'd0;
            tcent   <= tcent + 2'd1;
          end else begin
            tmod100 <= tmod100 + 7'd1;
          end
        end
      end
      OP_FIX: begin
        dsvalid <= (year >= DST_FIRST_YEAR);
        if ((r == DST_MIN_DAY) && leapy) begin
          r <= r + 7'd7;
        end
      end
      OP_DIG: begin
        if (cw.qput) begin
          frame <= frame | ({57'd0, dr} << cw.rpos) | ({57'd0, dq[3:0]} << cw.qpos);
        end else begin
          frame <= frame | ({57'd0, dr} << cw.rpos);
        end
        if (cw.qkeep) begin
          tmp <= dq;
        end
      end
      OP_EMIT: begin
        if (emit_fire) begin
          out_frame <= fin;
        end
      end
      default: begin
        tmp <= tmp;
      end
    endcase
  end

  // An accepted word always starts the program at its first working step.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (pc == PC_INIT))
    else $error("accepted word did not start the program");

  // The emit step holds while the output register is still full and stalled.
  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    ((cw.op == OP_EMIT) && out_valid && !tc_out.ready) |=> (pc == $past(pc)))
    else $error("emit step moved on while the output was stalled");

  // The start-day walk leaves its candidate inside the week that starts at 67.
  a_dst_range: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_FIX) |-> ((r >= DST_MIN_DAY) && (r <= DST_MIN_DAY + 7'd6)))
    else $error("daylight-saving start day out of range");

  // Input is only taken while no word is in progress.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    ((cw.op != OP_WAIT) && $past(accept)) |-> !tc_in.ready)
    else $error("input ready while a word is in progress");

endmodule
`default_nettype wire
